FILE: sv/llcp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the least-loaded chunk placer.
// No dependencies; every other file imports this package.
package llcp_pkg;

    // Table and run limits
    localparam int MAX_SERVERS = 16;
    localparam int MAX_CHUNKS  = 64;

    // Field widths
    localparam int IDX_W   = $clog2(MAX_SERVERS);
    localparam int CNT_W   = $clog2(MAX_SERVERS + 1);
    localparam int LOAD_W  = 40;
    localparam int LAST_W  = 32;
    localparam int CHUNK_W = 20;
    localparam int FILE_W  = 31;
    localparam int ILOAD_W = 32;

    // Stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((2 * ILOAD_W + FILE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((IDX_W + CHUNK_W + 7) / 8) * 8;

    // Chunk size after reset
    localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(30000);

    // Saturation value of a server load
    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

    // Item kinds carried on the input tuser
    localparam logic FUNC_REGISTER = 1'b0;
    localparam logic FUNC_UPLOAD   = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SERVERS = 2'd1,
        ST_TOO_MANY   = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    // Commands from controller to datapath
    typedef struct packed {
        logic    accept;      // latch an input transaction
        logic    do_register; // append a server and build its result
        logic    set_status;  // build a single error result
        t_status status;      // code for set_status
        logic    scan_init;   // restart the table scan
        logic    scan_step;   // compare one table entry
        logic    place;       // place one chunk on the best server
        logic    emit;        // move pending result to the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic func;       // kind of the latched item
        logic table_full;
        logic no_servers;
        logic too_many;
        logic scan_last;  // scan is at the last valid entry
        logic res_last;   // pending result closes the run
        logic out_free;   // output register can take a result
    } t_sts;

endpackage

FILE: sv/least_loaded_chunk_placer_top.sv
`timescale 1ns / 1ps
// Least-loaded chunk placer: keeps a table of up to 16 servers with a load and a last-chunk
// size each. A register transaction (tuser 0) appends a server and returns its index; an
// upload transaction (tuser 1) cuts the file into chunks of the configured size and places
// each chunk on the server with the smallest (load + last chunk) / 2, lowest index on ties,
// emitting one result per chunk with tlast on the final one. A register transaction passes
// through a decode and an emit state. An upload is decoded, then for each chunk the min
// search walks the server table one entry per cycle, a place state updates the table and
// an emit state hands the result to the output register, waiting while that is full. Error
// results (no servers, over 64 chunks, table full) go through decode and emit. The output
// register lets the next transaction be accepted while the last result still waits. The
// chunk size port is always ready and may be written only while the block is idle.
// Depends on llcp_pkg, llcp_ctrl and llcp_datapath.
module least_loaded_chunk_placer_top import llcp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,  // initial_load, initial_last_chunk, file_bytes
    input  logic                   i_s_tuser,  // func
    // Result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,  // server_index, chunk_length
    output logic                   o_m_tlast,
    output logic [1:0]             o_m_tuser,  // status
    // Chunk size register
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CHUNK_W-1:0]     i_cfg_data
);

    t_cmd               cmd;
    t_sts               sts;
    logic [IDX_W-1:0]   server_index;
    logic [CHUNK_W-1:0] chunk_length;
    t_status            status;

    assign o_cfg_ready = 1'b1;

    llcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    llcp_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_func               (i_s_tuser),
        .i_initial_load       (i_s_tdata[ILOAD_W-1:0]),
        .i_initial_last_chunk (i_s_tdata[2*ILOAD_W-1:ILOAD_W]),
        .i_file_bytes         (i_s_tdata[2*ILOAD_W+FILE_W-1:2*ILOAD_W]),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_data           (i_cfg_data),
        .i_out_ready          (i_m_tready),
        .o_out_valid          (o_m_tvalid),
        .o_server_index       (server_index),
        .o_chunk_length       (chunk_length),
        .o_last               (o_m_tlast),
        .o_status             (status)
    );

    // Pack result payload
    assign o_m_tdata = OUT_TDATA_W'({chunk_length, server_index});
    assign o_m_tuser = status;

endmodule

FILE: sv/llcp_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the least-loaded chunk placer.
// Depends on llcp_pkg; drives llcp_datapath through t_cmd / t_sts.
module llcp_ctrl import llcp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_PLACE  = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_EMIT;
                if (i_sts.func == FUNC_REGISTER) begin
                    if (i_sts.table_full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_FULL;
                    end else begin
                        o_cmd.do_register = 1'b1;
                    end
                end else if (i_sts.no_servers) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NO_SERVERS;
                end else if (i_sts.too_many) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_TOO_MANY;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                // Wait for room in the output register
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/llcp_datapath.sv
`timescale 1ns / 1ps
// Server table, chunk arithmetic, min search and output register.
// Depends on llcp_pkg; commanded by llcp_ctrl.
module llcp_datapath import llcp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    // Input transaction payload
    input  logic                   i_func,
    input  logic [ILOAD_W-1:0]     i_initial_load,
    input  logic [ILOAD_W-1:0]     i_initial_last_chunk,
    input  logic [FILE_W-1:0]      i_file_bytes,
    // Configuration write
    input  logic                   i_cfg_valid,
    input  logic [CHUNK_W-1:0]     i_cfg_data,
    // Output register
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [IDX_W-1:0]       o_server_index,
    output logic [CHUNK_W-1:0]     o_chunk_length,
    output logic                   o_last,
    output t_status                o_status
);

    // Server table, only entries below the count are ever read
    logic [LOAD_W-1:0]  r_load [MAX_SERVERS];
    logic [LAST_W-1:0]  r_lastc[MAX_SERVERS];
    logic [CNT_W-1:0]   r_count;
    logic [CHUNK_W-1:0] r_chunk;

    // Latched item
    logic               r_func;
    logic [ILOAD_W-1:0] r_init_load;
    logic [ILOAD_W-1:0] r_init_last;
    logic [FILE_W-1:0]  r_remaining;

    // Scan state
    logic [IDX_W-1:0]   r_scan;
    logic [IDX_W-1:0]   r_best_idx;
    logic [LOAD_W-1:0]  r_best_pri;
    logic [LOAD_W-1:0]  r_best_load;

    // Pending result
    logic [IDX_W-1:0]   r_res_idx;
    logic [CHUNK_W-1:0] r_res_len;
    logic               r_res_last;
    t_status            r_res_status;

    // Output register
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic [CHUNK_W-1:0] r_out_len;
    logic               r_out_last;
    t_status            r_out_status;

    logic [CHUNK_W-1:0] c_eff;
    logic [31:0]        max_bytes;
    logic [LOAD_W:0]    scan_sum;
    logic [LOAD_W-1:0]  scan_pri;
    logic               scan_take;
    logic [CHUNK_W-1:0] chunk_len;
    logic [LOAD_W:0]    new_load;
    logic [FILE_W-1:0]  rem_after;

    // Zero chunk size acts as one byte
    assign c_eff = (r_chunk == '0) ? CHUNK_W'(1) : r_chunk;

    // Largest file that still fits in the chunk limit
    assign max_bytes = 32'(c_eff) * 32'(MAX_CHUNKS);

    // Priority of the entry under the scan pointer
    assign scan_sum  = (LOAD_W+1)'(r_load[r_scan]) + (LOAD_W+1)'(r_lastc[r_scan]);
    assign scan_pri  = scan_sum[LOAD_W:1];
    assign scan_take = (r_scan == '0) || (scan_pri < r_best_pri);

    // Chunk length and saturating load update
    assign chunk_len = (r_remaining < FILE_W'(c_eff)) ? r_remaining[CHUNK_W-1:0] : c_eff;
    assign new_load  = (LOAD_W+1)'(r_best_load) + (LOAD_W+1)'(chunk_len);
    assign rem_after = r_remaining - FILE_W'(chunk_len);

    // Status toward the controller
    assign o_sts.func       = r_func;
    assign o_sts.table_full = (r_count == CNT_W'(MAX_SERVERS));
    assign o_sts.no_servers = (r_count == '0);
    assign o_sts.too_many   = (32'(r_remaining) > max_bytes);
    assign o_sts.scan_last  = ({1'b0, r_scan} == (r_count - CNT_W'(1)));
    assign o_sts.res_last   = r_res_last;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    // Hold configuration and server count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= CHUNK_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_chunk <= i_cfg_data;
            end
            if (i_cmd.do_register) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Latch item, run scan, update table, build pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func      <= i_func;
            r_init_load <= i_initial_load;
            r_init_last <= i_initial_last_chunk;
            r_remaining <= i_file_bytes;
        end
        if (i_cmd.scan_init) begin
            r_scan <= '0;
        end
        if (i_cmd.scan_step) begin
            r_scan <= r_scan + IDX_W'(1);
            if (scan_take) begin
                r_best_idx  <= r_scan;
                r_best_pri  <= scan_pri;
                r_best_load <= r_load[r_scan];
            end
        end
        if (i_cmd.do_register) begin
            r_load[r_count[IDX_W-1:0]]  <= LOAD_W'(r_init_load);
            r_lastc[r_count[IDX_W-1:0]] <= r_init_last;
            r_res_idx    <= r_count[IDX_W-1:0];
            r_res_len    <= '0;
            r_res_last   <= 1'b1;
            r_res_status <= ST_OK;
        end
        if (i_cmd.set_status) begin
            r_res_idx    <= '0;
            r_res_len    <= '0;
            r_res_last   <= 1'b1;
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.place) begin
            r_lastc[r_best_idx] <= LAST_W'(chunk_len);
            r_load[r_best_idx]  <= new_load[LOAD_W] ? LOAD_MAX : new_load[LOAD_W-1:0];
            r_remaining         <= rem_after;
            r_res_idx           <= r_best_idx;
            r_res_len           <= chunk_len;
            r_res_last          <= (r_remaining <= FILE_W'(c_eff));
            r_res_status        <= ST_OK;
        end
    end

    // Output valid: set on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_idx    <= r_res_idx;
            r_out_len    <= r_res_len;
            r_out_last   <= r_res_last;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_server_index = r_out_idx;
    assign o_chunk_length = r_out_len;
    assign o_last         = r_out_last;
    assign o_status       = r_out_status;

endmodule

FILE: sv/llcp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the least-loaded chunk placer, bound to the top level.
// Depends on llcp_pkg and least_loaded_chunk_placer_top.
module llcp_checker import llcp_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tlast,
    input logic [1:0]             o_m_tuser
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // Error results are single, closing and empty
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_OK) |-> o_m_tlast && (o_m_tdata == '0))
        else $error("malformed error result");

    // One transaction at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second transaction taken while busy");

    // Leaving reset: idle and empty
    a_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_s_tready && !o_m_tvalid)
        else $error("bad state after reset");

endmodule

bind least_loaded_chunk_placer_top llcp_checker u_llcp_checker (.*);
